/* rtl/pursuit_velocity_command_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pursuit velocity command block
// Shared helpers that wrap concurrent assertions on clk with rst disable.
// ---------------------------------------------------------------------------
`ifndef PURSUIT_VELOCITY_COMMAND_DEFINES_SVH
`define PURSUIT_VELOCITY_COMMAND_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define PVC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pursuit velocity command: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define PVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pursuit velocity command: next-cycle check failed");

`endif

/* rtl/pvc_pkg.sv */
// ---------------------------------------------------------------------------
// pvc_pkg
// Types, register codes and fixed-point constants of the pursuit block.
// ---------------------------------------------------------------------------
package pvc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_YAW_GAIN   = 2'd0;
  localparam logic [1:0] CFG_SPEED_GAIN = 2'd1;

  localparam logic [15:0] YAW_GAIN_RST   = 16'd16384;
  localparam logic [15:0] SPEED_GAIN_RST = 16'd2048;

  localparam int GAIN_FRAC = 12;

  // Saturation limits of the three commands.
  localparam logic signed [47:0] YAW_MAX   = 48'sd823550;
  localparam logic [47:0]        SPEED_MAX = 48'd1518500250;
  localparam logic [31:0]        CLIMB_MAX = 32'd11863283;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Arctangent of 2^-i in Q.30 radians.
  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  // Round a Q.30 angle half up to f fraction bits.
  function automatic logic [31:0] q30_to_frac(input logic [31:0] q, input int unsigned f);
    logic [32:0] t;
    t = {1'b0, q} + (33'd1 << (29 - f));
    return 32'(t >> (30 - f));
  endfunction

endpackage

/* rtl/pursuit_velocity_command.sv */
// Each item passes through 37 register stages between the inputs and out_valid.
// Throughput: one item per cycle unless the pipeline holds; the 32-stage planar square root sets the depth.
// The whole pipeline advances together and holds while a result waits to be taken.
// Reset (rst, synchronous) clears all valid bits and loads the default gains.
// ---------------------------------------------------------------------------
// pursuit_velocity_command
// Bearing, planar distance and climb commands from a leader offset.
// ---------------------------------------------------------------------------
`include "pursuit_velocity_command_defines.svh"

module pursuit_velocity_command
  import pvc_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] rel_x,
  input  logic signed [31:0] rel_y,
  input  logic signed [31:0] rel_z,
  input  logic               position_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] yaw_rate,
  output logic [30:0]        forward_speed,
  output logic signed [24:0] climb_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int L   = 37;
  localparam int XW  = 35;
  localparam int ZW  = FRAC_BITS + 3;
  localparam int PW  = ZW + 17;
  localparam int CS  = CORDIC_STAGES;
  localparam int DY  = 33 - CS;
  localparam int CRW = (32 + FRAC_BITS) + ((32 + FRAC_BITS) % 2);
  localparam int CRB = CRW / 2;
  localparam int DC  = 35 - CRB;

  logic        adv;
  logic [L-1:0] vld;
  logic [L-1:0] pvd;
  logic [15:0] yaw_gain;
  logic [15:0] speed_gain;

  assign adv       = ~vld[L-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[L-1];
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_gain   <= YAW_GAIN_RST;
      speed_gain <= SPEED_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_YAW_GAIN:   yaw_gain <= cfg_data;
        CFG_SPEED_GAIN: speed_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid and position flags travel along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pvd <= {pvd[L-2:0], position_valid};
    end
  end

  // Stage 0: input register.
  logic signed [31:0] s_x, s_y, s_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      s_x <= rel_x;
      s_y <= rel_y;
      s_z <= rel_z;
    end
  end

  logic [31:0] ax, ay, az;
  assign ax = s_x[31] ? 32'(-s_x) : 32'(s_x);
  assign ay = s_y[31] ? 32'(-s_y) : 32'(s_y);
  assign az = s_z[31] ? 32'(-s_z) : 32'(s_z);

  // ---------------- bearing: CORDIC vectoring ----------------
  logic signed [XW-1:0] cx [0:CS];
  logic signed [XW-1:0] cy [0:CS];
  logic signed [ZW-1:0] cz [0:CS];
  logic signed [XW-1:0] ex, ey;
  logic signed [ZW-1:0] hp;

  assign ex = XW'(s_x);
  assign ey = XW'(s_y);
  assign hp = ZW'(q30_to_frac(HALF_PI_Q30, FRAC_BITS));

  // Left half plane vectors are turned by a quarter turn first.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!s_x[31]) begin
        cx[0] <= ex;
        cy[0] <= ey;
        cz[0] <= '0;
      end else if (!s_y[31]) begin
        cx[0] <= ey;
        cy[0] <= -ex;
        cz[0] <= hp;
      end else begin
        cx[0] <= -ey;
        cy[0] <= ex;
        cz[0] <= -hp;
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign at = ZW'(q30_to_frac(ATAN_Q30[i], FRAC_BITS));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + at;
        end else if (cy[i] < 0) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i];
          cy[i+1] <= cy[i];
          cz[i+1] <= cz[i];
        end
      end
    end
  end

  // Angle delay line up to the gain multiplier.
  logic signed [ZW-1:0] yd [0:DY-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      yd[0] <= cz[CS];
    end
  end
  for (genvar j = 1; j < DY; j++) begin : g_yd
    always_ff @(posedge clk) begin
      if (adv) begin
        yd[j] <= yd[j-1];
      end
    end
  end

  // ---------------- planar distance ----------------
  logic [63:0] sqx, sqy, sqsum;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx   <= 64'(ax) * 64'(ax);
      sqy   <= 64'(ay) * 64'(ay);
      sqsum <= sqx + sqy;
    end
  end

  logic [31:0] plane_dist;
  logic        dist_side;
  pvc_isqrt #(.RW(64), .SW(1)) u_dist_sqrt (
    .clk      (clk),
    .en       (adv),
    .rad      (sqsum),
    .side_in  (1'b0),
    .root     (plane_dist),
    .side_out (dist_side)
  );

  // ---------------- climb root ----------------
  logic [CRW-1:0] crad;
  logic [CRB-1:0] croot;
  logic           csign;
  assign crad = CRW'({az, {FRAC_BITS{1'b0}}});

  pvc_isqrt #(.RW(CRW), .SW(1)) u_climb_sqrt (
    .clk      (clk),
    .en       (adv),
    .rad      (crad),
    .side_in  (s_z[31]),
    .root     (croot),
    .side_out (csign)
  );

  logic [CRB:0] cd [0:DC-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      cd[0] <= {csign, croot};
    end
  end
  for (genvar j = 1; j < DC; j++) begin : g_cd
    always_ff @(posedge clk) begin
      if (adv) begin
        cd[j] <= cd[j-1];
      end
    end
  end

  // ---------------- gain products ----------------
  logic signed [PW-1:0] ang_ext, ygain_ext, yprod;
  logic [47:0]          sprod;
  assign ang_ext   = PW'(yd[DY-1]);
  assign ygain_ext = PW'($signed({1'b0, yaw_gain}));

  always_ff @(posedge clk) begin
    if (adv) begin
      yprod <= ang_ext * ygain_ext;
      sprod <= 48'(plane_dist) * 48'(speed_gain) + 48'(dist_side);
    end
  end

  // ---------------- saturation and output register ----------------
  logic signed [47:0] ysh;
  logic [47:0]        ssh;
  logic [31:0]        cmag;
  logic signed [20:0] yaw_sat;
  logic [30:0]        spd_sat;
  logic signed [24:0] clm_sat;

  assign ysh  = (48'(yprod)) >>> GAIN_FRAC;
  assign ssh  = sprod >> GAIN_FRAC;
  assign cmag = (32'(cd[DC-1][CRB-1:0]) > CLIMB_MAX) ? CLIMB_MAX :
                32'(cd[DC-1][CRB-1:0]);

  always_comb begin
    if (ysh > YAW_MAX) begin
      yaw_sat = 21'(YAW_MAX);
    end else if (ysh < -YAW_MAX) begin
      yaw_sat = 21'(-YAW_MAX);
    end else begin
      yaw_sat = 21'(ysh);
    end
    spd_sat = (ssh > SPEED_MAX) ? 31'(SPEED_MAX) : 31'(ssh);
    clm_sat = cd[DC-1][CRB] ? -(25'(cmag)) : 25'(cmag);
  end

  // Invalid positions give all-zero commands.
  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_rate      <= pvd[L-2] ? yaw_sat : '0;
      forward_speed <= pvd[L-2] ? spd_sat : '0;
      climb_rate    <= pvd[L-2] ? clm_sat : '0;
    end
  end

  // ---------------- assertions ----------------
  `PVC_ASSERT_SAME(a_zero_invalid, out_valid && !pvd[L-1],
                   yaw_rate == 0 && forward_speed == 0 && climb_rate == 0)
  `PVC_ASSERT_SAME(a_stall_holds_input, out_valid && !out_ready, !in_ready)
  `PVC_ASSERT_SAME(a_speed_range, out_valid, 48'(forward_speed) <= SPEED_MAX)
  `PVC_ASSERT_NEXT(a_entry_valid, in_valid && in_ready, vld[0])

endmodule

/* rtl/pvc_isqrt.sv */
// ---------------------------------------------------------------------------
// pvc_isqrt
// Pipelined floor integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module pvc_isqrt #(
  parameter int RW = 64,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW-1:0]     rad,
  input  logic [SW-1:0]     side_in,
  output logic [RW/2-1:0]   root,
  output logic [SW-1:0]     side_out
);

  localparam int N    = RW / 2;
  localparam int REMW = N + 2;

  logic [RW-1:0]   rad_s  [0:N];
  logic [REMW-1:0] rem_s  [0:N];
  logic [N-1:0]    res_s  [0:N];
  logic [SW-1:0]   side_s [0:N];

  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign res_s[0]  = '0;
  assign side_s[0] = side_in;

  // Each stage brings down two radicand bits and tries one root bit.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [REMW-1:0] rem_new;
    logic [REMW-1:0] trial;
    logic            ge;

    assign rem_new = {rem_s[k][REMW-3:0], rad_s[k][RW-1:RW-2]};
    assign trial   = {res_s[k], 2'b01};
    assign ge      = rem_new >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1]  <= rad_s[k] << 2;
        rem_s[k+1]  <= ge ? rem_new - trial : rem_new;
        res_s[k+1]  <= {res_s[k][N-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign root     = res_s[N];
  assign side_out = side_s[N];

endmodule
